[src/tfp_pkg.sv]
// Shared types and constants for the tag file line parser.
package tfp_pkg;

	localparam int CNT_W = 6;

	// byte values
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// result kinds
	localparam logic [3:0] K_SNAME = 4'd0;
	localparam logic [3:0] K_SVAL  = 4'd2;
	localparam logic [3:0] K_SEND  = 4'd3;
	localparam logic [3:0] K_BNAME = 4'd4;
	localparam logic [3:0] K_BVAL  = 4'd6;
	localparam logic [3:0] K_BLEND = 4'd7;
	localparam logic [3:0] K_BEND  = 4'd8;
	localparam logic [3:0] K_ERR   = 4'd9;
	localparam logic [3:0] K_DONE  = 4'd10;

	// error codes
	localparam logic [2:0] E_NONE   = 3'd0;
	localparam logic [2:0] E_ORPHAN = 3'd1;
	localparam logic [2:0] E_EOFBLK = 3'd2;
	localparam logic [2:0] E_TAGLEN = 3'd3;
	localparam logic [2:0] E_BLANKS = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  out_byte;
		logic [2:0]  error_code;
		logic [19:0] line_number;
		logic        last_of_run;
	} res_t;

	// run of results that precedes the single ones of a request
	typedef enum logic [1:0] {PRE_NONE, PRE_TAG, PRE_BLANK, PRE_MATCH} pre_t;

	typedef struct packed {
		pre_t             pre;
		logic [CNT_W-1:0] pre_n;
		logic             dot_seen;
		logic [CNT_W-1:0] dot_pos;
		logic [CNT_W-1:0] body;
		logic [3:0]       base;
		logic             has_a;
		logic [3:0]       a_kind;
		logic [7:0]       a_byte;
		logic [2:0]       a_err;
		logic             has_b;
		logic [19:0]      line;
	} cmd_t;

endpackage

[src/tfp_front.sv]
// Front end: parses input bytes, keeps the tag store, queues expansion commands.
module tfp_front #(
	parameter int TAG_BYTES   = 32,
	parameter int BLANK_DEPTH = 16,
	parameter int LINE_BITS   = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  tfp_pkg::in_t                  item,
	input  logic                          q_full,
	output logic                          cmd_push,
	output tfp_pkg::cmd_t                 cmd,
	input  logic                          pre_done,
	input  logic                          rb_en,
	input  logic [$clog2(TAG_BYTES)-1:0]  rb_addr,
	output logic [7:0]                    rb_data,
	output logic [BLANK_DEPTH-1:0]        blanks
);
	localparam int TI  = $clog2(TAG_BYTES);
	localparam int BI  = $clog2(BLANK_DEPTH);
	localparam int LW2 = (LINE_BITS > 20) ? LINE_BITS : 20;
	localparam int CW  = tfp_pkg::CNT_W;

	typedef enum logic [3:0] {
		M_START, M_SKIP, M_BLANK, M_STAG, M_SLEAD, M_SVAL,
		M_BTAG, M_BHEAD, M_BMATCH, M_BVAL, M_ERR
	} mode_t;

	mode_t          mode_q, mode_d;
	logic [CW-1:0]  len_q, len_d, dot_q, dot_d, bc_q, bc_d, m_q, m_d;
	logic           dseen_q, dseen_d, flush_q;
	logic [LINE_BITS-1:0] line_q;
	logic [BLANK_DEPTH-1:0] blank_q;
	logic [7:0]     mem [2**TI];
	logic [7:0]     ra_q;
	logic           acc, tag_we, blank_we, isb;
	logic [7:0]     b, expect_b;
	logic [CW-1:0]  body, m_dm1, m_inc;
	logic [LW2-1:0] line_ext;
	logic [19:0]    line_out;

	assign full   = q_full || flush_q;
	assign acc    = push && !full;
	assign b      = item.data_byte;
	assign isb    = (b == tfp_pkg::CH_SP) || (b == tfp_pkg::CH_TAB);
	assign blanks = blank_q;

	// saturated line number for results
	assign line_ext = LW2'(line_q);
	assign line_out = (line_ext > LW2'(20'hFFFFF)) ? 20'hFFFFF : line_ext[19:0];

	// end tag body length and expected byte of the end tag
	assign body  = (dseen_q && len_q != '0 && dot_q == len_q - CW'(1)) ? len_q - CW'(1) : len_q;
	assign m_inc = m_q + CW'(1);
	always_comb begin
		if (m_q == '0)
			expect_b = tfp_pkg::CH_MINUS;
		else if (m_q <= body)
			expect_b = ra_q;
		else
			expect_b = tfp_pkg::CH_COLON;
	end

	// parser next state
	always_comb begin
		mode_d   = mode_q;
		len_d    = len_q;
		dot_d    = dot_q;
		dseen_d  = dseen_q;
		bc_d     = bc_q;
		m_d      = m_q;
		tag_we   = 1'b0;
		blank_we = 1'b0;
		cmd      = '0;
		cmd.line = line_out;
		if (acc) begin
			if (item.end_of_input) begin
				mode_d    = M_START;
				len_d     = '0;
				dot_d     = '0;
				dseen_d   = 1'b0;
				bc_d      = '0;
				m_d       = '0;
				cmd.has_a = 1'b1;
				cmd.has_b = 1'b1;
				unique case (mode_q)
					M_STAG, M_BTAG: begin
						cmd.a_kind = tfp_pkg::K_ERR;
						cmd.a_err  = tfp_pkg::E_ORPHAN;
					end
					M_SLEAD, M_SVAL: cmd.a_kind = tfp_pkg::K_SEND;
					M_BHEAD, M_BMATCH, M_BVAL: begin
						cmd.a_kind = tfp_pkg::K_ERR;
						cmd.a_err  = tfp_pkg::E_EOFBLK;
					end
					default: begin
						cmd.a_kind = tfp_pkg::K_DONE;
						cmd.has_b  = 1'b0;
					end
				endcase
			end else begin
				unique case (mode_q)
					M_START: begin
						if (b == tfp_pkg::CH_EQ || b == tfp_pkg::CH_PLUS) begin
							len_d   = '0;
							dot_d   = '0;
							dseen_d = 1'b0;
							mode_d  = (b == tfp_pkg::CH_EQ) ? M_STAG : M_BTAG;
						end else if (b == tfp_pkg::CH_HASH) begin
							mode_d = M_SKIP;
						end else if (isb || b == tfp_pkg::CH_CR) begin
							mode_d = M_BLANK;
						end else if (b != tfp_pkg::CH_LF) begin
							cmd.has_a  = 1'b1;
							cmd.a_kind = tfp_pkg::K_ERR;
							cmd.a_err  = tfp_pkg::E_ORPHAN;
							mode_d     = M_ERR;
						end
					end
					M_BLANK: begin
						if (b == tfp_pkg::CH_LF) begin
							mode_d = M_START;
						end else if (b == tfp_pkg::CH_HASH) begin
							mode_d = M_SKIP;
						end else if (!isb && b != tfp_pkg::CH_CR) begin
							cmd.has_a  = 1'b1;
							cmd.a_kind = tfp_pkg::K_ERR;
							cmd.a_err  = tfp_pkg::E_ORPHAN;
							mode_d     = M_ERR;
						end
					end
					M_SKIP: begin
						if (b == tfp_pkg::CH_LF)
							mode_d = M_START;
					end
					M_STAG, M_BTAG: begin
						if (b == tfp_pkg::CH_COLON) begin
							if (len_q != CW'(dseen_q)) begin
								cmd.pre = tfp_pkg::PRE_TAG;
							end
							cmd.pre_n    = len_q;
							cmd.dot_seen = dseen_q;
							cmd.dot_pos  = dot_q;
							cmd.base     = (mode_q == M_STAG) ? tfp_pkg::K_SNAME
								: tfp_pkg::K_BNAME;
							mode_d = (mode_q == M_STAG) ? M_SLEAD : M_BHEAD;
						end else if (isb || b == tfp_pkg::CH_CR || b == tfp_pkg::CH_LF) begin
							cmd.has_a  = 1'b1;
							cmd.a_kind = tfp_pkg::K_ERR;
							cmd.a_err  = tfp_pkg::E_ORPHAN;
							mode_d     = M_ERR;
						end else if (len_q >= CW'(TAG_BYTES)) begin
							cmd.has_a  = 1'b1;
							cmd.a_kind = tfp_pkg::K_ERR;
							cmd.a_err  = tfp_pkg::E_TAGLEN;
							mode_d     = M_ERR;
						end else begin
							if (b == tfp_pkg::CH_DOT) begin
								dseen_d = 1'b1;
								dot_d   = len_q;
							end
							tag_we = 1'b1;
							len_d  = len_q + CW'(1);
						end
					end
					M_SLEAD: begin
						if (b == tfp_pkg::CH_LF) begin
							cmd.has_a  = 1'b1;
							cmd.a_kind = tfp_pkg::K_SEND;
							mode_d     = M_START;
						end else if (!isb) begin
							cmd.has_a  = 1'b1;
							cmd.a_kind = tfp_pkg::K_SVAL;
							cmd.a_byte = b;
							bc_d       = '0;
							mode_d     = M_SVAL;
						end
					end
					M_SVAL: begin
						if (b == tfp_pkg::CH_LF) begin
							cmd.has_a  = 1'b1;
							cmd.a_kind = tfp_pkg::K_SEND;
							bc_d       = '0;
							mode_d     = M_START;
						end else if (isb) begin
							if (bc_q >= CW'(BLANK_DEPTH)) begin
								cmd.has_a  = 1'b1;
								cmd.a_kind = tfp_pkg::K_ERR;
								cmd.a_err  = tfp_pkg::E_BLANKS;
								mode_d     = M_ERR;
							end else begin
								blank_we = 1'b1;
								bc_d     = bc_q + CW'(1);
							end
						end else begin
							if (bc_q != '0)
								cmd.pre = tfp_pkg::PRE_BLANK;
							cmd.pre_n  = bc_q;
							cmd.has_a  = 1'b1;
							cmd.a_kind = tfp_pkg::K_SVAL;
							cmd.a_byte = b;
							bc_d       = '0;
						end
					end
					M_BHEAD: begin
						if (b == tfp_pkg::CH_LF) begin
							m_d    = '0;
							mode_d = M_BMATCH;
						end
					end
					M_BMATCH: begin
						if (b == expect_b) begin
							if (m_inc >= body + CW'(2)) begin
								cmd.has_a  = 1'b1;
								cmd.a_kind = tfp_pkg::K_BEND;
								m_d        = '0;
								mode_d     = M_SKIP;
							end else begin
								m_d = m_inc;
							end
						end else begin
							if (m_q != '0)
								cmd.pre = tfp_pkg::PRE_MATCH;
							cmd.pre_n = m_q;
							cmd.body  = body;
							cmd.has_a = 1'b1;
							m_d       = '0;
							if (b == tfp_pkg::CH_LF) begin
								cmd.a_kind = tfp_pkg::K_BLEND;
							end else begin
								cmd.a_kind = tfp_pkg::K_BVAL;
								cmd.a_byte = b;
								mode_d     = M_BVAL;
							end
						end
					end
					M_BVAL: begin
						cmd.has_a = 1'b1;
						if (b == tfp_pkg::CH_LF) begin
							cmd.a_kind = tfp_pkg::K_BLEND;
							m_d        = '0;
							mode_d     = M_BMATCH;
						end else begin
							cmd.a_kind = tfp_pkg::K_BVAL;
							cmd.a_byte = b;
						end
					end
					default: ;
				endcase
			end
		end
		cmd_push = acc && (cmd.has_a || cmd.pre != tfp_pkg::PRE_NONE);
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_START;
			len_q   <= '0;
			dot_q   <= '0;
			dseen_q <= 1'b0;
			bc_q    <= '0;
			m_q     <= '0;
			line_q  <= LINE_BITS'(1);
			flush_q <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			len_q   <= len_d;
			dot_q   <= dot_d;
			dseen_q <= dseen_d;
			bc_q    <= bc_d;
			m_q     <= m_d;
			if (acc && item.end_of_input)
				line_q <= LINE_BITS'(1);
			else if (acc && b == tfp_pkg::CH_LF && line_q != '1)
				line_q <= line_q + LINE_BITS'(1);
			if (cmd_push && cmd.pre != tfp_pkg::PRE_NONE)
				flush_q <= 1'b1;
			else if (pre_done)
				flush_q <= 1'b0;
		end
	end

	// pending blank kinds, 1 = tab
	always_ff @(posedge clk) begin
		if (blank_we)
			blank_q[bc_q[BI-1:0]] <= (b == tfp_pkg::CH_TAB);
	end

	// tag store: one write port, match lookahead port, back end port
	assign m_dm1 = m_d - CW'(1);
	always_ff @(posedge clk) begin
		if (tag_we)
			mem[len_q[TI-1:0]] <= b;
		ra_q <= mem[m_dm1[TI-1:0]];
		if (rb_en)
			rb_data <= mem[rb_addr];
	end

endmodule

[src/tfp_queue.sv]
// Two-entry command queue between the front end and the back end.
module tfp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  tfp_pkg::cmd_t wdata,
	output logic          q_full,
	input  logic          rd,
	output tfp_pkg::cmd_t rdata,
	output logic          q_empty
);
	tfp_pkg::cmd_t slot_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rdata   = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			slot_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wp_q <= !wp_q;
			if (rd)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

[src/tfp_back.sv]
// Back end: expands commands into result items, with an output register.
module tfp_back #(
	parameter int TAG_BYTES   = 32,
	parameter int BLANK_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tfp_pkg::cmd_t                 q_data,
	input  logic                          q_empty,
	output logic                          q_pop,
	output logic                          pre_done,
	output logic                          rb_en,
	output logic [$clog2(TAG_BYTES)-1:0]  rb_addr,
	input  logic [7:0]                    rb_data,
	input  logic [BLANK_DEPTH-1:0]        blanks,
	output logic                          empty,
	input  logic                          pop,
	output tfp_pkg::res_t                 result
);
	localparam int TI = $clog2(TAG_BYTES);
	localparam int BI = $clog2(BLANK_DEPTH);
	localparam int CW = tfp_pkg::CNT_W;

	typedef enum logic [1:0] {PH_IDLE, PH_PRE, PH_A, PH_B} phase_t;

	typedef struct packed {
		tfp_pkg::res_t res;
		logic          use_mem;
	} item_t;

	phase_t        phase_q, phase_d;
	tfp_pkg::cmd_t cur_q;
	logic [CW-1:0] idx_q, idx_m1, last_tag;
	item_t         nx, s1_s1;
	tfp_pkg::res_t s1_res;
	logic          s1_v_q, out_v_q, issue, step, can, out_rdy, is_last_i;

	assign out_rdy = !out_v_q || pop;
	assign can     = !s1_v_q || out_rdy;
	assign empty   = !out_v_q;
	assign idx_m1  = idx_q - CW'(1);
	assign last_tag = (cur_q.dot_seen && cur_q.dot_pos == cur_q.pre_n - CW'(1))
		? cur_q.pre_n - CW'(2) : cur_q.pre_n - CW'(1);
	assign is_last_i = (idx_q == cur_q.pre_n - CW'(1));
	assign rb_en   = issue && nx.use_mem;

	// result sequencer
	always_comb begin
		phase_d  = phase_q;
		issue    = 1'b0;
		step     = 1'b0;
		q_pop    = 1'b0;
		pre_done = 1'b0;
		rb_addr  = idx_q[TI-1:0];
		nx       = '0;
		nx.res.line_number = cur_q.line;
		unique case (phase_q)
			PH_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_data.pre != tfp_pkg::PRE_NONE)
						phase_d = PH_PRE;
					else if (q_data.has_a)
						phase_d = PH_A;
					else
						phase_d = PH_B;
				end
			end
			PH_PRE: begin
				unique case (cur_q.pre)
					tfp_pkg::PRE_TAG: begin
						nx.use_mem  = 1'b1;
						nx.res.kind = (cur_q.dot_seen && idx_q > cur_q.dot_pos)
							? cur_q.base + 4'd1 : cur_q.base;
						nx.res.last_of_run = (idx_q == last_tag) && !cur_q.has_a;
						if (cur_q.dot_seen && idx_q == cur_q.dot_pos) begin
							step = 1'b1;
						end else begin
							step  = can;
							issue = can;
						end
					end
					tfp_pkg::PRE_BLANK: begin
						nx.res.kind     = tfp_pkg::K_SVAL;
						nx.res.out_byte = blanks[idx_q[BI-1:0]] ? tfp_pkg::CH_TAB
							: tfp_pkg::CH_SP;
						step  = can;
						issue = can;
					end
					default: begin
						nx.res.kind = tfp_pkg::K_BVAL;
						rb_addr     = idx_m1[TI-1:0];
						if (idx_q == '0)
							nx.res.out_byte = tfp_pkg::CH_MINUS;
						else if (idx_q <= cur_q.body)
							nx.use_mem = 1'b1;
						else
							nx.res.out_byte = tfp_pkg::CH_COLON;
						step  = can;
						issue = can;
					end
				endcase
				if (step && is_last_i) begin
					pre_done = 1'b1;
					phase_d  = cur_q.has_a ? PH_A : PH_IDLE;
				end
			end
			PH_A: begin
				nx.res.kind        = cur_q.a_kind;
				nx.res.out_byte    = cur_q.a_byte;
				nx.res.error_code  = cur_q.a_err;
				nx.res.last_of_run = !cur_q.has_b;
				issue = can;
				if (can)
					phase_d = cur_q.has_b ? PH_B : PH_IDLE;
			end
			default: begin
				nx.res.kind        = tfp_pkg::K_DONE;
				nx.res.last_of_run = 1'b1;
				issue = can;
				if (can)
					phase_d = PH_IDLE;
			end
		endcase
	end

	// stage result with the tag store byte merged in
	always_comb begin
		s1_res = s1_s1.res;
		if (s1_s1.use_mem)
			s1_res.out_byte = rb_data;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
		if (issue)
			s1_s1 <= nx;
		if (s1_v_q && out_rdy)
			result <= s1_res;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (q_pop)
				idx_q <= '0;
			else if (step)
				idx_q <= idx_q + CW'(1);
			if (issue)
				s1_v_q <= 1'b1;
			else if (s1_v_q && out_rdy)
				s1_v_q <= 1'b0;
			if (s1_v_q && out_rdy)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

endmodule

[src/tag_file_line_parser.sv]
// Tag file line parser top level: front end, command queue and back end.
// Flow: the front end queues expansion commands in the two-entry command queue, so it can
// take new bytes while the back end is still expanding earlier ones; the back end takes each
// command and then issues its results in order, skipping the dot of a stored tag. A byte that
// releases a stored tag, pending blanks or a partial end tag holds input until the back end
// has issued the last result of that run; input is also held while the command queue is full.
// Reset: arst_n clears the parser to line start, line count one, queues empty.
module tag_file_line_parser #(
	parameter int TAG_BYTES   = 32,
	parameter int BLANK_DEPTH = 16,
	parameter int LINE_BITS   = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  tfp_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output tfp_pkg::res_t result
);
	localparam int TI = $clog2(TAG_BYTES);

	tfp_pkg::cmd_t          cmd, q_data;
	logic                   cmd_push, q_full, q_empty, q_pop, pre_done, rb_en;
	logic [TI-1:0]          rb_addr;
	logic [7:0]             rb_data;
	logic [BLANK_DEPTH-1:0] blanks;

	tfp_front #(
		.TAG_BYTES(TAG_BYTES), .BLANK_DEPTH(BLANK_DEPTH), .LINE_BITS(LINE_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.q_full(q_full), .cmd_push(cmd_push), .cmd(cmd), .pre_done(pre_done),
		.rb_en(rb_en), .rb_addr(rb_addr), .rb_data(rb_data), .blanks(blanks)
	);

	tfp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(cmd_push), .wdata(cmd), .q_full(q_full),
		.rd(q_pop), .rdata(q_data), .q_empty(q_empty)
	);

	tfp_back #(
		.TAG_BYTES(TAG_BYTES), .BLANK_DEPTH(BLANK_DEPTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_data(q_data), .q_empty(q_empty), .q_pop(q_pop),
		.pre_done(pre_done), .rb_en(rb_en), .rb_addr(rb_addr), .rb_data(rb_data),
		.blanks(blanks), .empty(empty), .pop(pop), .result(result)
	);

endmodule

[sim/tb.sv]
// Testbench for the tag file line parser: random-gap queue driver, prediction and result check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// parse states of the predictor
	typedef enum int {P_START, P_SKIP, P_BLANK, P_STAG, P_SLEAD, P_SVAL,
		P_BTAG, P_BHEAD, P_BMATCH, P_BVAL, P_ERR} pstate_t;

	localparam int TAGN = 32;
	localparam int BLKN = 16;
	localparam int WATCH_LIMIT = 20000;
	localparam logic [7:0] CH_A = 8'h41;

	logic clk, arst_n, push, full, empty, pop;
	tfp_pkg::in_t item;
	tfp_pkg::res_t result;

	tag_file_line_parser DUT (.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.item(item), .empty(empty), .pop(pop), .result(result));

	// predictor state
	pstate_t mode;
	logic [7:0] tag_buf [TAGN];
	int tag_len, dot_pos, blank_n, match_n;
	bit dot_seen;
	bit blank_tab [BLKN];
	logic [19:0] line_cnt;

	tfp_pkg::res_t expected_q [$];
	tfp_pkg::res_t run_q [$];
	tfp_pkg::in_t pending_q [$];
	int errors;
	int watch;
	bit stim_done;
	bit hold_push;
	bit in_taken;
	bit out_taken;

	// append one predicted result to the current request's run
	function automatic void emit(logic [3:0] k, logic [7:0] b, logic [2:0] e);
		tfp_pkg::res_t r;
		r.kind = k;
		r.out_byte = b;
		r.error_code = e;
		r.line_number = line_cnt;
		r.last_of_run = 1'b0;
		run_q = {run_q, r};
	endfunction

	function automatic void parse_fail(logic [2:0] e);
		emit(tfp_pkg::K_ERR, 8'd0, e);
		mode = P_ERR;
	endfunction

	function automatic void clear_state();
		mode = P_START;
		tag_len = 0;
		dot_pos = 0;
		dot_seen = 0;
		blank_n = 0;
		match_n = 0;
		line_cnt = 20'd1;
	endfunction

	function automatic bit is_blank(logic [7:0] b);
		return b == tfp_pkg::CH_SP || b == tfp_pkg::CH_TAB;
	endfunction

	function automatic void open_tag(pstate_t m);
		tag_len = 0;
		dot_pos = 0;
		dot_seen = 0;
		mode = m;
	endfunction

	// name bytes then modifier bytes of the stored tag
	function automatic void release_tag(logic [3:0] name_k);
		for (int i = 0; i < tag_len; i++) begin
			if (dot_seen && i == dot_pos)
				continue;
			emit((dot_seen && i > dot_pos) ? name_k + 4'd1 : name_k, tag_buf[i],
				tfp_pkg::E_NONE);
		end
	endfunction

	// returns 1 when the colon closes the tag
	function automatic bit take_tag_byte(logic [7:0] b);
		if (b == tfp_pkg::CH_COLON)
			return 1;
		if (is_blank(b) || b == tfp_pkg::CH_CR || b == tfp_pkg::CH_LF) begin
			parse_fail(tfp_pkg::E_ORPHAN);
			return 0;
		end
		if (tag_len >= TAGN) begin
			parse_fail(tfp_pkg::E_TAGLEN);
			return 0;
		end
		if (b == tfp_pkg::CH_DOT) begin
			dot_seen = 1;
			dot_pos = tag_len;
		end
		tag_buf[tag_len] = b;
		tag_len++;
		return 0;
	endfunction

	function automatic int end_body();
		if (dot_seen && tag_len > 0 && dot_pos == tag_len - 1)
			return tag_len - 1;
		return tag_len;
	endfunction

	function automatic logic [7:0] end_char(int k);
		if (k == 0)
			return tfp_pkg::CH_MINUS;
		if (k <= end_body())
			return tag_buf[k - 1];
		return tfp_pkg::CH_COLON;
	endfunction

	// expected results of one request, appended to expected_q
	function automatic void predict_parse(tfp_pkg::in_t it);
		logic [7:0] b;
		b = it.data_byte;
		run_q.delete();
		if (it.end_of_input) begin
			case (mode)
				P_STAG, P_BTAG: emit(tfp_pkg::K_ERR, 8'd0, tfp_pkg::E_ORPHAN);
				P_SLEAD, P_SVAL: emit(tfp_pkg::K_SEND, 8'd0, tfp_pkg::E_NONE);
				P_BHEAD, P_BMATCH, P_BVAL: emit(tfp_pkg::K_ERR, 8'd0, tfp_pkg::E_EOFBLK);
				default: ;
			endcase
			emit(tfp_pkg::K_DONE, 8'd0, tfp_pkg::E_NONE);
			clear_state();
		end else begin
			case (mode)
				P_START: begin
					if (b == tfp_pkg::CH_EQ) open_tag(P_STAG);
					else if (b == tfp_pkg::CH_PLUS) open_tag(P_BTAG);
					else if (b == tfp_pkg::CH_HASH) mode = P_SKIP;
					else if (is_blank(b) || b == tfp_pkg::CH_CR) mode = P_BLANK;
					else if (b != tfp_pkg::CH_LF) parse_fail(tfp_pkg::E_ORPHAN);
				end
				P_BLANK: begin
					if (b == tfp_pkg::CH_LF) mode = P_START;
					else if (b == tfp_pkg::CH_HASH) mode = P_SKIP;
					else if (!is_blank(b) && b != tfp_pkg::CH_CR)
						parse_fail(tfp_pkg::E_ORPHAN);
				end
				P_SKIP: if (b == tfp_pkg::CH_LF) mode = P_START;
				P_STAG: if (take_tag_byte(b)) begin
					release_tag(tfp_pkg::K_SNAME);
					mode = P_SLEAD;
				end
				P_SLEAD: begin
					if (b == tfp_pkg::CH_LF) begin
						emit(tfp_pkg::K_SEND, 8'd0, tfp_pkg::E_NONE);
						mode = P_START;
					end else if (!is_blank(b)) begin
						emit(tfp_pkg::K_SVAL, b, tfp_pkg::E_NONE);
						blank_n = 0;
						mode = P_SVAL;
					end
				end
				P_SVAL: begin
					if (b == tfp_pkg::CH_LF) begin
						emit(tfp_pkg::K_SEND, 8'd0, tfp_pkg::E_NONE);
						blank_n = 0;
						mode = P_START;
					end else if (is_blank(b)) begin
						if (blank_n >= BLKN) parse_fail(tfp_pkg::E_BLANKS);
						else begin
							blank_tab[blank_n] = (b == tfp_pkg::CH_TAB);
							blank_n++;
						end
					end else begin
						for (int i = 0; i < blank_n; i++)
							emit(tfp_pkg::K_SVAL, blank_tab[i] ? tfp_pkg::CH_TAB
								: tfp_pkg::CH_SP, tfp_pkg::E_NONE);
						blank_n = 0;
						emit(tfp_pkg::K_SVAL, b, tfp_pkg::E_NONE);
					end
				end
				P_BTAG: if (take_tag_byte(b)) begin
					release_tag(tfp_pkg::K_BNAME);
					mode = P_BHEAD;
				end
				P_BHEAD: if (b == tfp_pkg::CH_LF) begin
					match_n = 0;
					mode = P_BMATCH;
				end
				P_BMATCH: begin
					if (b == end_char(match_n)) begin
						match_n++;
						if (match_n >= end_body() + 2) begin
							emit(tfp_pkg::K_BEND, 8'd0, tfp_pkg::E_NONE);
							match_n = 0;
							mode = P_SKIP;
						end
					end else begin
						for (int i = 0; i < match_n; i++)
							emit(tfp_pkg::K_BVAL, end_char(i), tfp_pkg::E_NONE);
						match_n = 0;
						if (b == tfp_pkg::CH_LF) emit(tfp_pkg::K_BLEND, 8'd0, tfp_pkg::E_NONE);
						else begin
							emit(tfp_pkg::K_BVAL, b, tfp_pkg::E_NONE);
							mode = P_BVAL;
						end
					end
				end
				P_BVAL: begin
					if (b == tfp_pkg::CH_LF) begin
						emit(tfp_pkg::K_BLEND, 8'd0, tfp_pkg::E_NONE);
						match_n = 0;
						mode = P_BMATCH;
					end else emit(tfp_pkg::K_BVAL, b, tfp_pkg::E_NONE);
				end
				default: ;
			endcase
			if (b == tfp_pkg::CH_LF && line_cnt != 20'hFFFFF)
				line_cnt++;
		end
		if (run_q.size() > 0)
			run_q[run_q.size() - 1].last_of_run = 1'b1;
		expected_q = {expected_q, run_q};
	endfunction

	// stimulus helpers
	function automatic void put_byte(logic [7:0] b);
		tfp_pkg::in_t it;
		it.data_byte = b;
		it.end_of_input = 1'b0;
		pending_q = {pending_q, it};
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic void put_eoi();
		tfp_pkg::in_t it;
		it.data_byte = 8'($urandom);
		it.end_of_input = 1'b1;
		pending_q = {pending_q, it};
	endfunction

	function automatic logic [7:0] any_char();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = 8'($urandom);
			1: c = CH_A + 8'($urandom_range(0, 25));
			2: c = tfp_pkg::CH_DOT;
			default: c = 8'h61 + 8'($urandom_range(0, 25));
		endcase
		return c;
	endfunction

	// byte for tag text: any byte but colon, blank, CR or LF
	function automatic logic [7:0] tag_char();
		logic [7:0] c;
		c = ($urandom_range(0, 5) == 0) ? tfp_pkg::CH_DOT : any_char();
		while (c == tfp_pkg::CH_COLON || is_blank(c) || c == tfp_pkg::CH_CR
			|| c == tfp_pkg::CH_LF)
			c = any_char();
		return c;
	endfunction

	function automatic string rand_tag(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, string'(tag_char())};
		return s;
	endfunction

	function automatic void put_value_line();
		int n;
		logic [7:0] c;
		n = $urandom_range(0, 12);
		for (int i = 0; i < n; i++) begin
			c = ($urandom_range(0, 3) == 0)
				? (($urandom_range(0, 1) != 0) ? tfp_pkg::CH_TAB : tfp_pkg::CH_SP)
				: 8'($urandom);
			if (c == tfp_pkg::CH_LF) c = tfp_pkg::CH_SP;
			put_byte(c);
		end
		put_byte(tfp_pkg::CH_LF);
	endfunction

	function automatic void gen_stream();
		string t;
		int k;
		k = $urandom_range(0, 9);
		if (k < 4) begin
			t = rand_tag($urandom_range(1, 6));
			put_text({"=", t, ":"});
			put_value_line();
		end else if (k < 7) begin
			t = rand_tag($urandom_range(1, 5));
			if ($urandom_range(0, 3) == 0) t = {t, "."};
			put_text({"+", t, ":x\n"});
			repeat ($urandom_range(0, 3)) begin
				if ($urandom_range(0, 1) != 0) put_text({"-", t.substr(0,
					$urandom_range(0, t.len() - 1)), "\n"});
				else put_value_line();
			end
			if (t[t.len() - 1] == tfp_pkg::CH_DOT) t = t.substr(0, t.len() - 2);
			if ($urandom_range(0, 7) != 0) put_text({"-", t, ":\n"});
		end else if (k == 7) put_text("  # note\n");
		else if (k == 8) put_byte(tfp_pkg::CH_LF);
		else repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
		if ($urandom_range(0, 5) == 0) put_eoi();
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stimulus: directed cases, then random line streams
	initial begin
		string long_tag;
		errors = 0;
		stim_done = 0;
		hold_push = 0;
		clear_state();
		put_text("=A.b.c:  v\t x  \n");
		put_text("=N:\n# c\n \r\n+B.:\n-B.\n-B:\n");
		put_eoi();
		put_text("+T.m:h\nx\n-T.m:\n");
		put_byte(8'hFF);
		put_byte(8'h00);
		put_eoi();
		put_text("=Q:a");
		put_text("                 b");
		put_eoi();
		long_tag = "";
		for (int i = 0; i <= TAGN; i++)
			long_tag = {long_tag, "z"};
		put_text({"=", long_tag});
		put_eoi();
		put_text("=a b");
		put_eoi();
		put_text("+Z:\n-Z");
		put_eoi();
		put_text("=R:v");
		put_eoi();
		put_eoi();
		wait (pending_q.size() == 0);
		hold_push = 1;
		wait (expected_q.size() == 0);
		repeat (10) @(posedge clk);
		hold_push = 0;
		while (pending_q.size() < 170)
			gen_stream();
		put_eoi();
		wait (pending_q.size() == 0);
		stim_done = 1;
	end

	// driver: changes inputs at the falling edge, one drawn gap per request
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		int g;
		g = $urandom_range(0, 5);
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
			send_gap <= 0;
		end else if (push && in_taken) begin
			// accepted at the last rising edge; load the next one or idle
			if (g == 0 && pending_q.size() > 0 && !hold_push) begin
				item <= pending_q[0];
				push <= 1'b1;
			end else begin
				push <= 1'b0;
				send_gap <= (g > 0) ? g - 1 : 0;
			end
		end else if (!push) begin
			if (send_gap > 0) send_gap <= send_gap - 1;
			else if (pending_q.size() > 0 && !hold_push) begin
				item <= pending_q[0];
				push <= 1'b1;
			end
		end
	end

	// receiver stall, one drawn gap per result
	int pop_gap;
	bit accepted;
	always @(negedge clk or negedge arst_n) begin
		int g;
		g = $urandom_range(0, 5);
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap <= 0;
		end else if (pop_gap > 0) begin
			pop <= 1'b0;
			pop_gap <= pop_gap - 1;
		end else if (out_taken && g > 0) begin
			pop <= 1'b0;
			pop_gap <= g - 1;
		end else begin
			pop <= 1'b1;
		end
	end

	// monitor: prediction on input accept, result check on output accept
	always @(posedge clk) begin
		tfp_pkg::res_t e;
		accepted = 0;
		if (arst_n) begin
			if (push && !full) begin
				accepted = 1;
				predict_parse(item);
				void'(pending_q.pop_front());
			end
			if (pop && !empty) begin
				accepted = 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, result);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (result !== e) begin
						$display("%0t: mismatch expected %h actual %h", $realtime, e, result);
						errors++;
					end
				end
			end
			watch <= accepted ? 0 : watch + 1;
		end
		in_taken <= arst_n && push && !full;
		out_taken <= arst_n && pop && !empty;
	end

	// reset, end of run and watchdog
	initial begin
		arst_n = 1'b0;
		watch = 0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;
		fork
			begin
				wait (stim_done && expected_q.size() == 0);
				repeat (40) @(posedge clk);
				if (errors == 0 && expected_q.size() == 0)
					$display("PASS tag_file_line_parser");
				else
					$display("FAIL tag_file_line_parser");
			end
			begin
				wait (watch >= WATCH_LIMIT);
				$display("timeout");
				$display("FAIL tag_file_line_parser");
			end
		join_any
		$finish;
	end
endmodule
